### rtl/core/odq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_pkg: shared types and constants of the ordered deque core
// Request kinds, status codes, state encoding and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package odq_pkg;

   localparam int VALUE_W      = 32;
   localparam int KIND_W       = 3;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 5;
   localparam int CAPACITY_DEF = 16;

   localparam logic [VALUE_W-1:0] NONE_VALUE = {VALUE_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_DELETE     = 3'd4,
      KIND_INSERT     = 3'd5
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_code_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_UP_RD,
      S_UP_WR,
      S_RM_RD,
      S_RM_CAP,
      S_DN_RD,
      S_DN_WR,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_ZERO,
      CUR_OCC,
      CUR_LAST,
      CUR_INC,
      CUR_DEC
   } cur_op_type;

   typedef enum logic [1:0] {
      POS_HOLD,
      POS_ZERO,
      POS_OCC,
      POS_CUR
   } pos_op_type;

   typedef enum logic [1:0] {
      RD_CUR,
      RD_CUR_M1,
      RD_CUR_P1
   } rd_sel_type;

   typedef enum logic {
      WD_RDATA,
      WD_VALUE
   } wr_sel_type;

   typedef struct packed {
      logic            load;
      logic            st_set;
      status_code_type st_code;
      cur_op_type      cur_op;
      pos_op_type      pos_op;
      logic            mem_rd;
      rd_sel_type      rd_sel;
      logic            mem_wr;
      wr_sel_type      wr_sel;
      logic            occ_inc;
      logic            occ_dec;
      logic            cap_removed;
      logic            rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic cur_at_occ;
      logic cur_at_pos;
      logic cur_p1_at_occ;
      logic entry_less;
      logic entry_equal;
      logic rsp_free;
   } stat_type;

endpackage
`default_nettype wire

### rtl/core/odq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_req_if: request channel of the ordered deque core
// Valid/ready channel carrying the request kind and its operand.
// ----------------------------------------------------------------------------
interface odq_req_if;
   logic                               valid;
   logic                               ready;
   logic [odq_pkg::KIND_W-1:0]         req_type;
   logic signed [odq_pkg::VALUE_W-1:0] operand_value;

   modport source (output valid, output req_type, output operand_value, input ready);
   modport sink (input valid, input req_type, input operand_value, output ready);
endinterface
`default_nettype wire

### rtl/core/odq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_rsp_if: response channel of the ordered deque core
// Valid/ready channel carrying the removed value, status and entry count.
// ----------------------------------------------------------------------------
interface odq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [odq_pkg::VALUE_W-1:0] removed_value;
   logic [odq_pkg::STATUS_W-1:0]       status;
   logic [odq_pkg::COUNT_W-1:0]        entry_count;

   modport source (output valid, output removed_value, output status, output entry_count,
                   input ready);
   modport sink (input valid, input removed_value, input status, input entry_count,
                 output ready);
endinterface
`default_nettype wire

### rtl/core/odq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_datapath: entry memory, cursors and response register
// Holds the entries in a single-port-write memory with a registered read,
// the occupancy, the scan cursor and insert position, and the output word.
// ----------------------------------------------------------------------------
module odq_datapath #(
   parameter int CAPACITY = odq_pkg::CAPACITY_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic signed [odq_pkg::VALUE_W-1:0] operand_value,
   input  wire odq_pkg::cmd_type                   cmd,
   output odq_pkg::stat_type                       stat,
   odq_rsp_if.source                               rsp
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   logic [odq_pkg::VALUE_W-1:0] mem [CAPACITY];

   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] cur_p1, cur_m1, occ_m1;

   logic signed [odq_pkg::VALUE_W-1:0] value_ff, value_in;
   logic signed [odq_pkg::VALUE_W-1:0] rdata_ff;
   logic signed [odq_pkg::VALUE_W-1:0] removed_ff, removed_in;
   odq_pkg::status_code_type           status_ff, status_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [odq_pkg::VALUE_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [odq_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [odq_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic [ADDR_W-1:0]           rd_addr;
   logic [ADDR_W-1:0]           wr_addr;
   logic [odq_pkg::VALUE_W-1:0] wr_data;

   assign cur_p1  = cur_ff + 1'b1;
   assign cur_m1  = cur_ff - 1'b1;
   assign occ_m1  = occ_ff - 1'b1;
   assign wr_addr = cur_ff[ADDR_W-1:0];

   always_comb begin
      case (cmd.rd_sel)
         odq_pkg::RD_CUR:    rd_addr = cur_ff[ADDR_W-1:0];
         odq_pkg::RD_CUR_M1: rd_addr = cur_m1[ADDR_W-1:0];
         odq_pkg::RD_CUR_P1: rd_addr = cur_p1[ADDR_W-1:0];
         default:            rd_addr = cur_ff[ADDR_W-1:0];
      endcase
   end

   assign wr_data = (cmd.wr_sel == odq_pkg::WD_VALUE) ? value_ff : rdata_ff;

   // Entry memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.occ_inc) begin
         occ_in = occ_ff + 1'b1;
      end else if (cmd.occ_dec) begin
         occ_in = occ_m1;
      end
   end

   always_comb begin
      case (cmd.cur_op)
         odq_pkg::CUR_HOLD: cur_in = cur_ff;
         odq_pkg::CUR_ZERO: cur_in = '0;
         odq_pkg::CUR_OCC:  cur_in = occ_ff;
         odq_pkg::CUR_LAST: cur_in = occ_m1;
         odq_pkg::CUR_INC:  cur_in = cur_p1;
         odq_pkg::CUR_DEC:  cur_in = cur_m1;
         default:           cur_in = cur_ff;
      endcase
   end

   always_comb begin
      case (cmd.pos_op)
         odq_pkg::POS_HOLD: pos_in = pos_ff;
         odq_pkg::POS_ZERO: pos_in = '0;
         odq_pkg::POS_OCC:  pos_in = occ_ff;
         odq_pkg::POS_CUR:  pos_in = cur_ff;
         default:           pos_in = pos_ff;
      endcase
   end

   always_comb begin
      value_in   = cmd.load ? operand_value : value_ff;
      removed_in = removed_ff;
      if (cmd.load) begin
         removed_in = odq_pkg::NONE_VALUE;
      end else if (cmd.cap_removed) begin
         removed_in = rdata_ff;
      end
      status_in = cmd.st_set ? cmd.st_code : status_ff;
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_removed_in = removed_ff;
         rsp_status_in  = status_ff;
         rsp_count_in   = odq_pkg::COUNT_W'(occ_ff);
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         cur_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff       <= value_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign stat.full          = (occ_ff == CNT_W'(CAPACITY));
   assign stat.empty         = (occ_ff == '0);
   assign stat.cur_at_occ    = (cur_ff == occ_ff);
   assign stat.cur_at_pos    = (cur_ff == pos_ff);
   assign stat.cur_p1_at_occ = (cur_p1 == occ_ff);
   assign stat.entry_less    = (rdata_ff < value_ff);
   assign stat.entry_equal   = (rdata_ff == value_ff);
   assign stat.rsp_free      = !rsp_valid_ff || rsp.ready;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.removed_value = rsp_removed_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.entry_count   = rsp_count_ff;

endmodule
`default_nettype wire

### rtl/core/odq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_ctrl: request sequencer of the ordered deque core
// Decodes each request and steps the datapath through search, shift-up and
// shift-down passes over the entry memory, then hands over the response.
// ----------------------------------------------------------------------------
module odq_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [odq_pkg::KIND_W-1:0] req_type,
   output logic                            req_ready,
   input  wire odq_pkg::stat_type          stat,
   output odq_pkg::cmd_type                cmd
);

   odq_pkg::state_type         state_ff, state_in;
   logic [odq_pkg::KIND_W-1:0] op_ff, op_in;
   logic                       is_insert;

   assign is_insert = (op_ff == odq_pkg::KIND_INSERT);

   always_comb begin
      op_in = (state_ff == odq_pkg::S_IDLE && req_valid) ? req_type : op_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= odq_pkg::S_IDLE;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         odq_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  odq_pkg::KIND_PUSH_FRONT, odq_pkg::KIND_PUSH_BACK:
                     state_in = stat.full ? odq_pkg::S_FINISH : odq_pkg::S_UP_RD;
                  odq_pkg::KIND_INSERT:
                     state_in = stat.full ? odq_pkg::S_FINISH : odq_pkg::S_SRCH_RD;
                  odq_pkg::KIND_POP_FRONT, odq_pkg::KIND_POP_BACK:
                     state_in = stat.empty ? odq_pkg::S_FINISH : odq_pkg::S_RM_RD;
                  odq_pkg::KIND_DELETE:
                     state_in = odq_pkg::S_SRCH_RD;
                  default:
                     state_in = odq_pkg::S_FINISH;
               endcase
            end
         end
         odq_pkg::S_SRCH_RD: begin
            if (stat.cur_at_occ) begin
               state_in = is_insert ? odq_pkg::S_UP_RD : odq_pkg::S_FINISH;
            end else begin
               state_in = odq_pkg::S_SRCH_CMP;
            end
         end
         odq_pkg::S_SRCH_CMP: begin
            if (is_insert) begin
               state_in = stat.entry_less ? odq_pkg::S_SRCH_RD : odq_pkg::S_UP_RD;
            end else begin
               state_in = stat.entry_equal ? odq_pkg::S_DN_RD : odq_pkg::S_SRCH_RD;
            end
         end
         odq_pkg::S_UP_RD: begin
            state_in = stat.cur_at_pos ? odq_pkg::S_FINISH : odq_pkg::S_UP_WR;
         end
         odq_pkg::S_UP_WR:  state_in = odq_pkg::S_UP_RD;
         odq_pkg::S_RM_RD:  state_in = odq_pkg::S_RM_CAP;
         odq_pkg::S_RM_CAP: state_in = odq_pkg::S_DN_RD;
         odq_pkg::S_DN_RD: begin
            state_in = stat.cur_p1_at_occ ? odq_pkg::S_FINISH : odq_pkg::S_DN_WR;
         end
         odq_pkg::S_DN_WR:  state_in = odq_pkg::S_DN_RD;
         odq_pkg::S_FINISH: begin
            if (stat.rsp_free) begin
               state_in = odq_pkg::S_IDLE;
            end
         end
         default: state_in = odq_pkg::S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd         = '0;
      cmd.st_code = odq_pkg::ST_DONE;
      cmd.cur_op  = odq_pkg::CUR_HOLD;
      cmd.pos_op  = odq_pkg::POS_HOLD;
      cmd.rd_sel  = odq_pkg::RD_CUR;
      cmd.wr_sel  = odq_pkg::WD_RDATA;
      req_ready   = 1'b0;
      case (state_ff)
         odq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.st_set  = 1'b1;
               cmd.st_code = odq_pkg::ST_DONE;
               case (req_type)
                  odq_pkg::KIND_PUSH_FRONT: begin
                     if (stat.full) begin
                        cmd.st_code = odq_pkg::ST_FULL;
                     end
                     cmd.pos_op = odq_pkg::POS_ZERO;
                     cmd.cur_op = odq_pkg::CUR_OCC;
                  end
                  odq_pkg::KIND_PUSH_BACK: begin
                     if (stat.full) begin
                        cmd.st_code = odq_pkg::ST_FULL;
                     end
                     cmd.pos_op = odq_pkg::POS_OCC;
                     cmd.cur_op = odq_pkg::CUR_OCC;
                  end
                  odq_pkg::KIND_INSERT: begin
                     if (stat.full) begin
                        cmd.st_code = odq_pkg::ST_FULL;
                     end
                     cmd.cur_op = odq_pkg::CUR_ZERO;
                  end
                  odq_pkg::KIND_POP_FRONT: begin
                     if (stat.empty) begin
                        cmd.st_code = odq_pkg::ST_EMPTY;
                     end
                     cmd.cur_op = odq_pkg::CUR_ZERO;
                  end
                  odq_pkg::KIND_POP_BACK: begin
                     if (stat.empty) begin
                        cmd.st_code = odq_pkg::ST_EMPTY;
                     end
                     cmd.cur_op = odq_pkg::CUR_LAST;
                  end
                  odq_pkg::KIND_DELETE: begin
                     cmd.cur_op = odq_pkg::CUR_ZERO;
                  end
                  default: begin
                     cmd.cur_op = odq_pkg::CUR_HOLD;
                  end
               endcase
            end
         end
         odq_pkg::S_SRCH_RD: begin
            if (stat.cur_at_occ) begin
               if (is_insert) begin
                  // Nothing is not less than the value: it goes to the back.
                  cmd.pos_op = odq_pkg::POS_CUR;
                  cmd.cur_op = odq_pkg::CUR_OCC;
               end else begin
                  cmd.st_set  = 1'b1;
                  cmd.st_code = odq_pkg::ST_EMPTY;
               end
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = odq_pkg::RD_CUR;
            end
         end
         odq_pkg::S_SRCH_CMP: begin
            if (is_insert) begin
               if (stat.entry_less) begin
                  cmd.cur_op = odq_pkg::CUR_INC;
               end else begin
                  cmd.pos_op = odq_pkg::POS_CUR;
                  cmd.cur_op = odq_pkg::CUR_OCC;
               end
            end else begin
               if (stat.entry_equal) begin
                  // The matching word is already in the read register.
                  cmd.cap_removed = 1'b1;
               end else begin
                  cmd.cur_op = odq_pkg::CUR_INC;
               end
            end
         end
         odq_pkg::S_UP_RD: begin
            if (stat.cur_at_pos) begin
               cmd.mem_wr  = 1'b1;
               cmd.wr_sel  = odq_pkg::WD_VALUE;
               cmd.occ_inc = 1'b1;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = odq_pkg::RD_CUR_M1;
            end
         end
         odq_pkg::S_UP_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = odq_pkg::WD_RDATA;
            cmd.cur_op = odq_pkg::CUR_DEC;
         end
         odq_pkg::S_RM_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = odq_pkg::RD_CUR;
         end
         odq_pkg::S_RM_CAP: begin
            cmd.cap_removed = 1'b1;
         end
         odq_pkg::S_DN_RD: begin
            if (stat.cur_p1_at_occ) begin
               cmd.occ_dec = 1'b1;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = odq_pkg::RD_CUR_P1;
            end
         end
         odq_pkg::S_DN_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = odq_pkg::WD_RDATA;
            cmd.cur_op = odq_pkg::CUR_INC;
         end
         odq_pkg::S_FINISH: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            cmd.rsp_load = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/ordered_deque_with_value_delete_core.sv
`default_nettype none
// Sequencing: a refused request or an unknown kind goes straight to the response word, and a
// push at the back writes its entry first; the others also search or move entries one by one
// before that, paced by the one-read, one-write entry memory.
// Throughput: one request at a time; the next is taken the cycle after the response
// word enters the output register, which holds it while the sink stalls.
// Reset: synchronous; clears occupancy and control, the entry memory is left as it is.
// ----------------------------------------------------------------------------
// ordered_deque_with_value_delete_core: bounded ordered deque of signed words
// Push and pop at both ends, delete of the first equal entry and insert before
// the first entry not less than a value, with one response per request.
// ----------------------------------------------------------------------------
module ordered_deque_with_value_delete_core #(
   parameter int CAPACITY = odq_pkg::CAPACITY_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   odq_req_if.sink   req,
   odq_rsp_if.source rsp
);

   odq_pkg::cmd_type  cmd;
   odq_pkg::stat_type stat;

   odq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_type  (req.req_type),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   odq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .operand_value (req.operand_value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp           (rsp)
   );

   // A response word is never loaded in the cycle a new request is taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(req.valid && req.ready))
      else $error("response loaded while a request was accepted");

   // Once the response word is loaded the block is ready for the next request.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> req.ready)
      else $error("not ready after response load");

   // The entry memory is never read and written in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_wr && cmd.mem_rd))
      else $error("entry memory read and written together");

   // The store can never be both full and empty.
   assert property (@(posedge clock) disable iff (reset)
      !(stat.full && stat.empty))
      else $error("occupancy flags inconsistent");

endmodule
`default_nettype wire

### verif/ordered_deque_with_value_delete_core_tb.sv
// ----------------------------------------------------------------------------
// ordered_deque_with_value_delete_core_tb: self-checking bench of the deque
// Drives push, pop, delete and ordered insert requests into the core and checks
// every response word against a behavioural copy of the deque held here.
// It covers empty and full stores, misses, extreme values, unknown kinds,
// random idling on both channels and a long response stall.
// ----------------------------------------------------------------------------
module ordered_deque_with_value_delete_core_tb;

   localparam int DEPTH         = odq_pkg::CAPACITY_DEF;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_WORDS  = 1350;
   localparam int REPORT_MAX    = 10;

   // Kinds that the core treats as no operation.
   localparam logic [odq_pkg::KIND_W-1:0] KIND_RSVD_LO = 3'd6;
   localparam logic [odq_pkg::KIND_W-1:0] KIND_RSVD_HI = 3'd7;

   localparam logic signed [odq_pkg::VALUE_W-1:0] MAX_VALUE = 32'h7FFF_FFFF;
   localparam logic signed [odq_pkg::VALUE_W-1:0] MIN_VALUE = 32'h8000_0000;

   typedef struct packed {
      logic signed [odq_pkg::VALUE_W-1:0] removed;
      logic [odq_pkg::STATUS_W-1:0]       status;
      logic [odq_pkg::COUNT_W-1:0]        count;
   } deque_result_type;

   logic clock;
   logic reset;

   odq_req_if req_ch ();
   odq_rsp_if rsp_ch ();

   ordered_deque_with_value_delete_core #(
      .CAPACITY(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   logic signed [odq_pkg::VALUE_W-1:0] deque_store [DEPTH];
   int                                 deque_fill;
   deque_result_type                   expected_results [$];
   int                                 mismatch_count = 0;
   bit                                 steady;
   int                                 hold_requests = 0;
   bit                                 growing;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic signed [odq_pkg::VALUE_W-1:0] take_entry(input int pos);
      logic signed [odq_pkg::VALUE_W-1:0] taken;
      int                                 i;
      taken = deque_store[pos];
      for (i = pos; i + 1 < deque_fill; i++) deque_store[i] = deque_store[i+1];
      deque_fill--;
      return taken;
   endfunction

   // Works out the response to one request and updates the deque copy.
   function automatic deque_result_type apply_request(
         input logic [odq_pkg::KIND_W-1:0] kind,
         input logic signed [odq_pkg::VALUE_W-1:0] value);
      deque_result_type res;
      int               pos;
      int               i;
      res.removed = odq_pkg::NONE_VALUE;
      res.status  = odq_pkg::ST_DONE;
      pos         = 0;
      case (kind)
         odq_pkg::KIND_PUSH_FRONT, odq_pkg::KIND_PUSH_BACK, odq_pkg::KIND_INSERT: begin
            if (deque_fill >= DEPTH) begin
               res.status = odq_pkg::ST_FULL;
            end else begin
               if (kind == odq_pkg::KIND_PUSH_BACK) begin
                  pos = deque_fill;
               end else if (kind == odq_pkg::KIND_INSERT) begin
                  while (pos < deque_fill && deque_store[pos] < value) pos++;
               end
               for (i = deque_fill; i > pos; i--) deque_store[i] = deque_store[i-1];
               deque_store[pos] = value;
               deque_fill++;
            end
         end
         odq_pkg::KIND_POP_FRONT, odq_pkg::KIND_POP_BACK: begin
            if (deque_fill == 0) begin
               res.status = odq_pkg::ST_EMPTY;
            end else begin
               res.removed = take_entry(kind == odq_pkg::KIND_POP_FRONT ? 0 : deque_fill - 1);
            end
         end
         odq_pkg::KIND_DELETE: begin
            while (pos < deque_fill && deque_store[pos] != value) pos++;
            if (pos < deque_fill) res.removed = take_entry(pos);
            else res.status = odq_pkg::ST_EMPTY;
         end
         default: ;
      endcase
      res.count = deque_fill[odq_pkg::COUNT_W-1:0];
      return res;
   endfunction

   // Half the time a narrow pool so that deletes hit and inserts land among equals.
   function automatic logic signed [odq_pkg::VALUE_W-1:0] pick_operand();
      logic signed [odq_pkg::VALUE_W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: v = $signed($urandom_range(8)) - 4;
         5:             v = $urandom_range(1) ? MAX_VALUE : MIN_VALUE;
         default:       v = $urandom;
      endcase
      return v;
   endfunction

   function automatic bit idle_roll();
      return !steady && ($urandom_range(99) < 6);
   endfunction

   // Offers one word and returns at the edge where it is taken.
   task automatic send_word(input logic [odq_pkg::KIND_W-1:0] kind,
                            input logic signed [odq_pkg::VALUE_W-1:0] value);
      @(negedge clock);
      while (idle_roll()) begin
         req_ch.valid         = 1'b0;
         req_ch.req_type      = odq_pkg::KIND_W'($urandom);
         req_ch.operand_value = $urandom;
         @(negedge clock);
      end
      req_ch.valid         = 1'b1;
      req_ch.req_type      = kind;
      req_ch.operand_value = value;
      do @(posedge clock); while (!req_ch.ready);
      expected_results.push_back(apply_request(kind, value));
   endtask

   // Picks a request whose mix follows the current fill or drain phase.
   task automatic send_random_request();
      logic [odq_pkg::KIND_W-1:0]         kind;
      logic signed [odq_pkg::VALUE_W-1:0] value;
      int                                 roll;
      if (deque_fill >= DEPTH) growing = 1'b0;
      else if (deque_fill == 0) growing = 1'b1;
      else if ($urandom_range(29) == 0) growing = !growing;
      roll  = $urandom_range(9);
      value = pick_operand();
      if ($urandom_range(99) < 2) begin
         kind = $urandom_range(1) ? KIND_RSVD_HI : KIND_RSVD_LO;
      end else if (growing ? roll < 7 : roll < 3) begin
         case ($urandom_range(3))
            0:       kind = odq_pkg::KIND_PUSH_FRONT;
            1:       kind = odq_pkg::KIND_PUSH_BACK;
            default: kind = odq_pkg::KIND_INSERT;
         endcase
      end else begin
         case ($urandom_range(3))
            0:       kind = odq_pkg::KIND_POP_FRONT;
            1:       kind = odq_pkg::KIND_POP_BACK;
            default: kind = odq_pkg::KIND_DELETE;
         endcase
         if (kind == odq_pkg::KIND_DELETE && deque_fill > 0 && $urandom_range(2) != 0)
            value = deque_store[$urandom_range(deque_fill - 1)];
      end
      send_word(kind, value);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_word(odq_pkg::KIND_POP_FRONT, 0);
      send_word(odq_pkg::KIND_POP_BACK, -1);
      send_word(odq_pkg::KIND_DELETE, 5);
      send_word(KIND_RSVD_LO, 0);
      send_word(KIND_RSVD_HI, -1);
      send_word(odq_pkg::KIND_PUSH_BACK, MAX_VALUE);
      send_word(odq_pkg::KIND_PUSH_FRONT, MIN_VALUE);
      send_word(odq_pkg::KIND_PUSH_BACK, -1);
      send_word(odq_pkg::KIND_PUSH_FRONT, 0);
      // Popping a stored -1 gives the same word as a miss, but with a done status.
      send_word(odq_pkg::KIND_POP_BACK, 0);
      send_word(odq_pkg::KIND_POP_FRONT, 0);
      send_word(odq_pkg::KIND_INSERT, 0);
      send_word(odq_pkg::KIND_INSERT, MIN_VALUE);
      send_word(odq_pkg::KIND_INSERT, MAX_VALUE);
      send_word(odq_pkg::KIND_DELETE, MAX_VALUE);
      send_word(odq_pkg::KIND_DELETE, MAX_VALUE);
      send_word(odq_pkg::KIND_INSERT, 7);
      send_word(odq_pkg::KIND_DELETE, 12345);
      send_word(odq_pkg::KIND_PUSH_BACK, 3);
      send_word(odq_pkg::KIND_PUSH_BACK, 3);
      send_word(odq_pkg::KIND_DELETE, 3);
      send_word(KIND_RSVD_HI, MAX_VALUE);
      drain_results();
   endtask

   // Filled and emptied without any idling on either side.
   task automatic test_full_store();
      bit from_front;
      steady = 1'b1;
      while (deque_fill < DEPTH) send_word(odq_pkg::KIND_INSERT, pick_operand());
      send_word(odq_pkg::KIND_PUSH_FRONT, pick_operand());
      send_word(odq_pkg::KIND_PUSH_BACK, pick_operand());
      send_word(odq_pkg::KIND_INSERT, pick_operand());
      send_word(odq_pkg::KIND_POP_BACK, 0);
      send_word(odq_pkg::KIND_PUSH_BACK, MIN_VALUE);
      send_word(KIND_RSVD_LO, MAX_VALUE);
      send_word(odq_pkg::KIND_INSERT, MAX_VALUE);
      from_front = 1'b1;
      while (deque_fill > 0) begin
         send_word(from_front ? odq_pkg::KIND_POP_FRONT : odq_pkg::KIND_POP_BACK, 0);
         from_front = !from_front;
      end
      send_word(odq_pkg::KIND_POP_FRONT, 0);
      drain_results();
      steady = 1'b0;
   endtask

   // The receiver holds off while requests keep coming, then the sender
   // waits for every response before going on.
   task automatic test_backpressure();
      int n;
      hold_requests++;
      for (n = 0; n < 30; n++) send_random_request();
      drain_results();
      for (n = 0; n < 10; n++) send_random_request();
      drain_results();
   endtask

   task automatic test_random();
      int n;
      for (n = 0; n < RANDOM_WORDS; n++) send_random_request();
      drain_results();
   endtask

   // Response side: random stalls, plus a long hold-off when one is asked for.
   initial begin : response_side
      int hold_left;
      int hold_seen;
      hold_left    = 0;
      hold_seen    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = !idle_roll();
         end
      end
   end

   always @(posedge clock) begin : check_response
      deque_result_type got;
      deque_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.removed = rsp_ch.removed_value;
         got.status  = rsp_ch.status;
         got.count   = rsp_ch.entry_count;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected response word: removed %0d status %0d count %0d",
                        got.removed, got.status, got.count);
         end else begin
            want = expected_results.pop_front();
            if (got.removed !== want.removed || got.status !== want.status ||
                got.count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("mismatch: removed %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
                           want.removed, got.removed, want.status, got.status,
                           want.count, got.count);
            end
         end
      end
   end

   // Ends the run if no word moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.req_type      = '0;
      req_ch.operand_value = '0;
      deque_fill           = 0;
      steady               = 1'b0;
      growing              = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_full_store();
      test_backpressure();
      test_random();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
